### rtl/bn_aff_pkg.sv
// ----------------------------------------------------------------------------
// bn_aff_pkg: shared types and constants for the batch-norm affine block
// Item layout, queue head, sequencer states and fixed-point widths.
// ----------------------------------------------------------------------------
package bn_aff_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH    = 4;

  localparam int FIELD_W = 16;  // sample, gain, bias, running_mean
  localparam int VAR_W   = 24;  // variance, unsigned Q8.16
  localparam int EPS_W   = 16;  // epsilon, unsigned Q0.16
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

  localparam logic MODE_PARAM = 1'b0;
  localparam logic MODE_DATA  = 1'b1;

  // Root: radicand is (variance + epsilon) << 32
  localparam int SUM_W      = VAR_W + 1;
  localparam int FRAC_SHIFT = 32;
  localparam int ROOT_W     = 29;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int ROOT_REM_W = ROOT_W + 2;

  // Divide: |gamma| << 32 over the root
  localparam int DVD_W = FIELD_W + FRAC_SHIFT;

  localparam int SCALE_W = 32;
  localparam int PROD_W  = FIELD_W + SCALE_W;
  localparam int DIFF_W  = PROD_W - 8 + 1;
  localparam int ACC_W   = PROD_W + 1;
  localparam int Y_W     = ACC_W - 16;

  localparam logic signed [SCALE_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [SCALE_W-1:0] S32_MIN = -32'sh7fff_ffff - 32'sd1;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  typedef struct packed {
    logic                      mode;
    logic signed [FIELD_W-1:0] sample;
    logic signed [FIELD_W-1:0] gain;
    logic signed [FIELD_W-1:0] bias;
    logic signed [FIELD_W-1:0] running_mean;
    logic [VAR_W-1:0]          variance;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_DIV,
    ST_SCALE,
    ST_MULM,
    ST_SHIFT,
    ST_DATA
  } st_t;

endpackage

### rtl/bn_aff_if.sv
// ----------------------------------------------------------------------------
// bn_aff_if: word channels of the batch-norm affine block
// Input item channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bn_in_if import bn_aff_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic signed [FIELD_W-1:0] sample;
  logic signed [FIELD_W-1:0] gain;
  logic signed [FIELD_W-1:0] bias;
  logic signed [FIELD_W-1:0] running_mean;
  logic [VAR_W-1:0]          variance;

  modport source (output valid, mode, sample, gain, bias, running_mean, variance,
                  input ready);
  modport sink   (input valid, mode, sample, gain, bias, running_mean, variance,
                  output ready);
endinterface

interface bn_out_if import bn_aff_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result;
  logic                         saturated;

  modport source (output valid, result, saturated, input ready);
  modport sink   (input valid, result, saturated, output ready);
endinterface

### rtl/bn_aff_front.sv
// ----------------------------------------------------------------------------
// bn_aff_front: input queue
// Take words from the input channel into a short FIFO; present the head.
// ----------------------------------------------------------------------------
module bn_aff_front import bn_aff_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  bn_in_if.sink   in_ch,
  output q_head_t head,
  input  logic    pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  item_t            in_item;

  assign in_ch.ready = (count_r != CNT_W'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    in_item.mode         = in_ch.mode;
    in_item.sample       = in_ch.sample;
    in_item.gain         = in_ch.gain;
    in_item.bias         = in_ch.bias;
    in_item.running_mean = in_ch.running_mean;
    in_item.variance     = in_ch.variance;
  end

  assign head.valid = (count_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'(DEPTH) && !pop |=> count_r == CNT_W'(DEPTH))
    else $error("queue count left full without a pop");
`endif

endmodule

### rtl/bn_aff_root.sv
// ----------------------------------------------------------------------------
// bn_aff_root: iterative integer square root
// One result bit per cycle of floor(sqrt(sum << 32)).
// ----------------------------------------------------------------------------
module bn_aff_root import bn_aff_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  sum,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0]      rad_r;
  logic [ROOT_REM_W-1:0] rem_r;
  logic [ROOT_W-1:0]     root_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [ROOT_REM_W+1:0] rem_t;
  logic [ROOT_REM_W+1:0] trial;
  logic                  fits;

  assign rem_t = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial = (ROOT_REM_W + 2)'({root_r, 2'b01});
  assign fits  = (rem_t >= trial);

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= {{(RAD_W - SUM_W - FRAC_SHIFT){1'b0}}, sum, {FRAC_SHIFT{1'b0}}};
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= fits ? ROOT_REM_W'(rem_t - trial) : ROOT_REM_W'(rem_t);
      root_r <= {root_r[ROOT_W-2:0], fits};
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(ROOT_W - 1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CNT_W'(ROOT_W - 1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### rtl/bn_aff_div.sv
// ----------------------------------------------------------------------------
// bn_aff_div: iterative restoring divider
// One quotient bit per cycle of (|gamma| << 32) / root.
// ----------------------------------------------------------------------------
module bn_aff_div import bn_aff_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [FIELD_W-1:0] mag,
  input  logic [ROOT_W-1:0]  divisor,
  output logic               done,
  output logic [DVD_W-1:0]   quot
);

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0]  dvd_r;
  logic [ROOT_W-1:0] rem_r;
  logic [ROOT_W-1:0] d_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [ROOT_W:0]   rem_t;
  logic              fits;

  assign rem_t = {rem_r, dvd_r[DVD_W-1]};
  assign fits  = (rem_t >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {mag, {FRAC_SHIFT{1'b0}}};
      rem_r <= '0;
      d_r   <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], fits};
      rem_r <= fits ? ROOT_W'(rem_t - {1'b0, d_r}) : ROOT_W'(rem_t);
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(DVD_W - 1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CNT_W'(DVD_W - 1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

### rtl/bn_aff_back.sv
// ----------------------------------------------------------------------------
// bn_aff_back: sequencer and datapath
// Load channel scale/shift from parameter words; apply them to data words.
// ----------------------------------------------------------------------------
module bn_aff_back import bn_aff_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  q_head_t          head,
  output logic             pop,
  input  logic [EPS_W-1:0] epsilon,
  bn_out_if.source         out_ch
);

  localparam int TOP_W = Y_W - DATA_WIDTH + 1;
  localparam logic signed [DATA_WIDTH-1:0] Y_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] Y_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  st_t state_r, state_nxt;

  logic signed [FIELD_W-1:0]    g_r;
  logic signed [FIELD_W-1:0]    b_r;
  logic signed [FIELD_W-1:0]    m_r;
  logic                         zero_r;
  logic signed [SCALE_W-1:0]    scale_r;
  logic signed [SCALE_W-1:0]    shift_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] result_r;
  logic                         sat_r;

  logic                         root_start, div_start, mul_load, out_load;
  logic                         root_done, div_done;
  logic [ROOT_W-1:0]            root;
  logic [DVD_W-1:0]             quot;
  logic [SUM_W-1:0]             sum;
  logic                         sum_zero;
  logic [FIELD_W-1:0]           g_mag;
  logic signed [FIELD_W-1:0]    mul_a;
  logic signed [PROD_W-1:0]     mul_p;
  logic signed [SCALE_W-1:0]    scale_nxt;
  logic signed [DIFF_W-1:0]     diff;
  logic signed [SCALE_W-1:0]    shift_nxt;
  logic [ACC_W-1:0]             acc;
  logic [Y_W-1:0]               y;
  logic [TOP_W-1:0]             y_top;
  logic signed [DATA_WIDTH-1:0] y_nxt;
  logic                         sat_nxt;

  assign sum      = {1'b0, head.item.variance} + SUM_W'(epsilon);
  assign sum_zero = (sum == '0);
  assign g_mag    = g_r[FIELD_W-1] ? FIELD_W'(~g_r + 1'b1) : g_r;

  bn_aff_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .sum   (sum),
    .done  (root_done),
    .root  (root)
  );

  bn_aff_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .mag     (g_mag),
    .divisor (root),
    .done    (div_done),
    .quot    (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    pop        = 1'b0;
    root_start = 1'b0;
    div_start  = 1'b0;
    mul_load   = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.item.mode == MODE_DATA) begin
            mul_load  = 1'b1;
            state_nxt = ST_DATA;
          end else if (sum_zero) begin
            state_nxt = ST_SCALE;
          end else begin
            root_start = 1'b1;
            state_nxt  = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: state_nxt = ST_MULM;
      ST_MULM: begin
        mul_load  = 1'b1;
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: state_nxt = ST_IDLE;
      ST_DATA: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // one shared 16x32 multiplier: sample * scale or mean * scale
  assign mul_a = (state_r == ST_MULM) ? m_r : head.item.sample;
  assign mul_p = mul_a * scale_r;

  // scale: saturate the signed quotient
  always_comb begin
    if (zero_r) begin
      if (g_r > 0) begin
        scale_nxt = S32_MAX;
      end else if (g_r < 0) begin
        scale_nxt = S32_MIN;
      end else begin
        scale_nxt = '0;
      end
    end else if (g_r[FIELD_W-1]) begin
      scale_nxt = SCALE_W'(~quot[SCALE_W-1:0] + 1'b1);
    end else if (quot[DVD_W-1:SCALE_W-1] != '0) begin
      scale_nxt = S32_MAX;
    end else begin
      scale_nxt = quot[SCALE_W-1:0];
    end
  end

  // shift = beta * 2^8 - floor(mean * scale / 2^8)
  always_comb begin
    diff = {{(DIFF_W - FIELD_W - 8){b_r[FIELD_W-1]}}, b_r, 8'b0}
         - {prod_r[PROD_W-1], prod_r[PROD_W-1:8]};
    if (diff[DIFF_W-1:SCALE_W-1] == '0 || diff[DIFF_W-1:SCALE_W-1] == '1) begin
      shift_nxt = diff[SCALE_W-1:0];
    end else begin
      shift_nxt = diff[DIFF_W-1] ? S32_MIN : S32_MAX;
    end
  end

  // y = round-half-up of (x * scale + shift * 2^8) / 2^16, then clip
  always_comb begin
    acc   = {prod_r[PROD_W-1], prod_r}
          + {{(ACC_W - SCALE_W - 8){shift_r[SCALE_W-1]}}, shift_r, 8'b0}
          + ROUND_HALF;
    y     = acc[ACC_W-1:16];
    y_top = y[Y_W-1:DATA_WIDTH-1];
    if (y_top == '0 || y_top == '1) begin
      y_nxt   = y[DATA_WIDTH-1:0];
      sat_nxt = 1'b0;
    end else begin
      y_nxt   = y[Y_W-1] ? Y_MIN : Y_MAX;
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.item.mode == MODE_PARAM) begin
      g_r    <= head.item.gain;
      b_r    <= head.item.bias;
      m_r    <= head.item.running_mean;
      zero_r <= sum_zero;
    end
    if (mul_load) begin
      prod_r <= mul_p;
    end
    if (out_load) begin
      result_r <= y_nxt;
      sat_r    <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= '0;
      shift_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_SCALE) begin
        scale_r <= scale_nxt;
      end
      if (state_r == ST_SHIFT) begin
        shift_r <= shift_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.result    = result_r;
  assign out_ch.saturated = sat_r;

`ifndef SYNTHESIS
  a_root_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> state_r == ST_ROOT)
    else $error("root finished while sequencer not waiting");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divide finished while sequencer not waiting");

  a_zero_gain_scale: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCALE && zero_r && g_r == '0 |=> scale_r == '0)
    else $error("zero gamma over zero root gave non-zero scale");
`endif

endmodule

### rtl/batchnorm_inference_affine.sv
// ----------------------------------------------------------------------------
// batchnorm_inference_affine: streaming batch-norm inference, fixed point
// in_ch takes words: mode 0 loads a channel (gamma, beta, mean, variance),
// mode 1 carries a sample x. out_ch gives one word per sample: y, Q8.8,
// with a flag when it was clipped. Parameter words give no result.
// cfg_we/cfg_wdata write epsilon (Q0.16); write only while the block is idle.
// Words pass through a four-deep queue to a sequencer, so the input keeps
// taking words while the sequencer or the receiver stalls.
// In the sequencer a sample is multiplied, then added, rounded and clipped
// into the output register; from an empty queue it passes the queue, the
// product register and the output register, which drives out_ch.valid.
// A parameter word passes dequeue, the bit-serial root and divide, scale,
// mean multiply and shift; no root or divide when variance + epsilon is 0.
// When out_ch stalls the result holds in the output register and the next
// sample waits in the sequencer; the queue fills, then in_ch.ready drops.
// Reset: synchronous, active low. Scale and shift clear to zero (samples
// before any parameter word give 0), epsilon returns to 1, queue empties.
// ----------------------------------------------------------------------------
module batchnorm_inference_affine import bn_aff_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  bn_in_if.sink            in_ch,
  bn_out_if.source         out_ch,
  input  logic             cfg_we,
  input  logic [EPS_W-1:0] cfg_wdata
);

  logic [EPS_W-1:0] epsilon_r;
  q_head_t          head;
  logic             pop;

  // epsilon register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epsilon_r <= EPS_RESET;
    end else if (cfg_we) begin
      epsilon_r <= cfg_wdata;
    end
  end

  // front: hold incoming words in order
  bn_aff_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  // back: update scale/shift or produce y, one word at a time
  bn_aff_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .pop     (pop),
    .epsilon (epsilon_r),
    .out_ch  (out_ch)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for batchnorm_inference_affine
// Streams channel-parameter and sample words through the block under random
// idling on both channels, with epsilon changed between idle phases. A
// fixed-point predictor of scale, shift and the saturated output runs on
// every accepted input word; each output word is checked against the oldest
// predicted result.
// ----------------------------------------------------------------------------
module tb;
  import bn_aff_pkg::*;

  localparam int          DW            = DATA_WIDTH_DEF;
  localparam int unsigned CYCLE_LIMIT   = 800000;
  // up to five parameter words can still be in flight
  localparam int          SETTLE_CYCLES = 500;
  localparam int          RANDOM_WORDS  = 306;  // per epsilon setting
  localparam int          HOLD_AFTER    = 400;  // results before the long receiver hold
  localparam int          HOLD_CYCLES   = 300;

  typedef struct packed {
    logic signed [DW-1:0] result;
    logic                 saturated;
  } bn_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [EPS_W-1:0] cfg_wdata;

  bn_in_if                     in_ch ();
  bn_out_if #(.DATA_WIDTH(DW)) out_ch ();

  batchnorm_inference_affine #(.DATA_WIDTH(DW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: the channel's scale and shift plus the epsilon register
  logic signed [SCALE_W-1:0] scale_q;
  logic signed [SCALE_W-1:0] shift_q;
  logic [EPS_W-1:0]          eps_q;

  item_t       pending_words[$];
  bn_result_t  expected_y_q[$];

  int unsigned words_queued  = 0;
  int unsigned words_in      = 0;
  int unsigned param_words   = 0;
  int unsigned sample_words  = 0;
  int unsigned results_seen  = 0;
  int unsigned clipped_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned eps_settings  = 1;
  int unsigned cycle_count   = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Give up well beyond the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_y_q.size());
      $display("batchnorm_inference_affine test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Fixed-point predictor
  // --------------------------------------------------------------------------

  // Bit-pair integer square root, floor
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned rt;
    longint unsigned bitv;
    rt   = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= rt + bitv) begin
        n  = n - (rt + bitv);
        rt = (rt >> 1) + bitv;
      end else begin
        rt = rt >> 1;
      end
      bitv = bitv >> 2;
    end
    return rt;
  endfunction

  function automatic logic signed [SCALE_W-1:0] clip32(input longint v);
    if (v > longint'(S32_MAX)) return S32_MAX;
    if (v < longint'(S32_MIN)) return S32_MIN;
    return v[SCALE_W-1:0];
  endfunction

  // Apply one accepted word: a parameter word reloads scale and shift, a
  // sample word queues its expected output.
  function automatic void bn_apply_word(input item_t w);
    longint          g, b, m, x, sc, acc, yv, hi, lo;
    longint unsigned s, r, mag, q;
    bn_result_t      res;
    if (w.mode == MODE_PARAM) begin
      g = longint'(w.gain);
      b = longint'(w.bias);
      m = longint'(w.running_mean);
      s = longint'(w.variance) + longint'(eps_q);
      if (s == 0) begin
        // zero root: saturate towards the sign of gamma
        if (g > 0)      sc = longint'(S32_MAX);
        else if (g < 0) sc = longint'(S32_MIN);
        else            sc = 0;
      end else begin
        r   = root_floor(s << FRAC_SHIFT);
        mag = longint'((g < 0) ? -g : g) << FRAC_SHIFT;
        q   = mag / r;
        sc  = (g < 0) ? -longint'(q) : longint'(q);
      end
      scale_q = clip32(sc);
      shift_q = clip32(b * 256 - ((m * longint'(scale_q)) >>> 8));
      param_words++;
    end else begin
      x   = longint'(w.sample);
      acc = x * longint'(scale_q) + longint'(shift_q) * 256 + 32768;
      yv  = acc >>> 16;
      hi  = (longint'(1) <<< (DW - 1)) - 1;
      lo  = -hi - 1;
      res.saturated = 1'b0;
      if (yv > hi) begin
        yv = hi;
        res.saturated = 1'b1;
      end
      if (yv < lo) begin
        yv = lo;
        res.saturated = 1'b1;
      end
      res.result = yv[DW-1:0];
      expected_y_q.push_back(res);
      sample_words++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Word construction
  // --------------------------------------------------------------------------

  function automatic item_t mk_word(input logic mode, input logic [15:0] x,
                                    input logic [15:0] g, input logic [15:0] b,
                                    input logic [15:0] m, input logic [23:0] v);
    item_t w;
    w.mode         = mode;
    w.sample       = x;
    w.gain         = g;
    w.bias         = b;
    w.running_mean = m;
    w.variance     = v;
    return w;
  endfunction

  // Q8.8 value weighted towards the extremes and towards small magnitudes
  function automatic logic [15:0] rand_q88();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 511)) - 16'd256;
      3:       return 16'($urandom_range(0, 8191)) - 16'd4096;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [23:0] rand_variance();
    case ($urandom_range(0, 7))
      0:       return 24'd0;
      1:       return 24'hff_ffff;
      2:       return 24'($urandom_range(0, 1023));
      3, 4:    return 24'($urandom() >> $urandom_range(8, 31));
      default: return 24'($urandom());
    endcase
  endfunction

  // Unused fields carry junk so that the block is seen to ignore them
  function automatic item_t rand_param();
    return mk_word(MODE_PARAM, 16'($urandom()), rand_q88(), rand_q88(), rand_q88(),
                   rand_variance());
  endfunction

  function automatic item_t rand_sample();
    return mk_word(MODE_DATA, rand_q88(), 16'($urandom()), 16'($urandom()),
                   16'($urandom()), 24'($urandom()));
  endfunction

  function automatic void queue_word(input item_t w);
    pending_words.push_back(w);
    words_queued++;
  endfunction

  // Mostly a channel load followed by a run of samples; the rest is loose
  // words: reloads with no sample between them and samples on a stale channel.
  function automatic void stream_random(input int n);
    int left;
    int k;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 99) < 85) begin
        queue_word(rand_param());
        left--;
        k = $urandom_range(1, 12);
        repeat (k) begin
          queue_word(rand_sample());
          left--;
        end
      end else begin
        k = $urandom_range(1, 3);
        repeat (k) begin
          if ($urandom_range(0, 1) != 0) queue_word(rand_param());
          else                           queue_word(rand_sample());
          left--;
        end
      end
    end
  endfunction

  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: advance to the next pending word once the current one has
  // been taken, with random gaps between words.
  // --------------------------------------------------------------------------
  int unsigned tx_gap    = 0;
  bit          tx_steady = 1'b0;

  always @(posedge clk) begin
    item_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        bn_apply_word(mk_word(in_ch.mode, in_ch.sample, in_ch.gain, in_ch.bias,
                              in_ch.running_mean, in_ch.variance));
        words_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.mode         <= w.mode;
          in_ch.sample       <= w.sample;
          in_ch.gain         <= w.gain;
          in_ch.bias         <= w.bias;
          in_ch.running_mean <= w.running_mean;
          in_ch.variance     <= w.variance;
          // flip into and out of back-to-back stretches now and then
          if ($urandom_range(0, 49) == 0) tx_steady = !tx_steady;
          tx_gap = pick_gap(tx_steady);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: check each accepted word against the oldest prediction,
  // and stall at random. Once, hold off for a long stretch so that the
  // block's queue fills and it stops taking input.
  // --------------------------------------------------------------------------
  int unsigned rx_stall  = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          rx_steady = 1'b0;

  function automatic void check_result(input logic signed [DW-1:0] y, input logic sat);
    bn_result_t exp_w;
    results_seen++;
    if (sat) clipped_seen++;
    if (expected_y_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected output word y=%0d sat=%0b", $realtime, y, sat);
      return;
    end
    exp_w = expected_y_q.pop_front();
    if (y !== exp_w.result || sat !== exp_w.saturated) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: output word %0d: expected y=%0d sat=%0b, got y=%0d sat=%0b",
                 $realtime, results_seen, exp_w.result, exp_w.saturated, y, sat);
    end
  endfunction

  // Long receiver hold, timed in cycles on its own
  always @(posedge clk) begin
    if (rst_n) begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result(out_ch.result, out_ch.saturated);
      if ($urandom_range(0, 199) == 0) rx_steady = !rx_steady;
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rx_stall = pick_gap(rx_steady);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------

  // Pause the sender until every word is in and every result is out, then
  // let parameter words that give no result finish in the block.
  task automatic settle_idle();
    while (!(words_in == words_queued && expected_y_q.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_epsilon(input logic [EPS_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    eps_q = v;
    eps_settings++;
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_PARAM;
    in_ch.sample       = '0;
    in_ch.gain         = '0;
    in_ch.bias         = '0;
    in_ch.running_mean = '0;
    in_ch.variance     = '0;
    out_ch.ready       = 1'b0;
    scale_q            = '0;
    shift_q            = '0;
    eps_q              = EPS_RESET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Samples before any channel load give zero
    queue_word(mk_word(MODE_DATA, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 24'hff_ffff));
    queue_word(mk_word(MODE_DATA, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 24'h00_0000));
    // Largest gamma, variance and mean with the most negative beta
    queue_word(mk_word(MODE_PARAM, 16'hffff, 16'h7fff, 16'h8000, 16'h7fff, 24'hff_ffff));
    queue_word(mk_word(MODE_DATA, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 24'h00_0000));
    queue_word(mk_word(MODE_DATA, 16'h8000, 16'hffff, 16'hffff, 16'hffff, 24'hff_ffff));
    queue_word(mk_word(MODE_DATA, 16'h0000, 16'h1234, 16'h5678, 16'h9abc, 24'h12_3456));
    // Most negative gamma on the smallest radicand: scale at its minimum, shift clips
    queue_word(mk_word(MODE_PARAM, 16'h5a5a, 16'h8000, 16'h7fff, 16'h8000, 24'h00_0000));
    queue_word(mk_word(MODE_DATA, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 24'h00_0000));
    queue_word(mk_word(MODE_DATA, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 24'h00_0000));
    queue_word(mk_word(MODE_DATA, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 24'h00_0000));
    // Near-unity scale
    queue_word(mk_word(MODE_PARAM, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 24'h01_0000));
    queue_word(mk_word(MODE_DATA, 16'h1234, 16'ha5a5, 16'h5a5a, 16'hc3c3, 24'hab_cdef));
    queue_word(mk_word(MODE_DATA, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 24'h00_0000));
    settle_idle();

    // Zero root: variance and epsilon both zero, gamma positive, negative, zero
    write_epsilon(16'h0000);
    queue_word(mk_word(MODE_PARAM, 16'h0000, 16'h7fff, 16'h0010, 16'h0100, 24'h00_0000));
    queue_word(mk_word(MODE_DATA, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 24'h00_0000));
    queue_word(mk_word(MODE_DATA, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h00_0000));
    queue_word(mk_word(MODE_PARAM, 16'h0000, 16'h8001, 16'h0000, 16'h0000, 24'h00_0000));
    queue_word(mk_word(MODE_DATA, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 24'h00_0000));
    queue_word(mk_word(MODE_PARAM, 16'h0000, 16'h0000, 16'h0100, 16'h7fff, 24'h00_0000));
    queue_word(mk_word(MODE_DATA, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 24'h00_0000));
    queue_word(mk_word(MODE_DATA, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 24'h00_0000));
    settle_idle();

    // Random streams, one per epsilon setting, extremes first
    stream_random(RANDOM_WORDS);
    settle_idle();
    write_epsilon(16'hffff);
    stream_random(RANDOM_WORDS);
    settle_idle();
    write_epsilon(16'($urandom()));
    stream_random(RANDOM_WORDS);
    settle_idle();
    write_epsilon(16'($urandom_range(0, 255)));
    stream_random(RANDOM_WORDS);
    settle_idle();
    write_epsilon(EPS_RESET);
    stream_random(RANDOM_WORDS);
    settle_idle();

    $display("covered %0d words (%0d channel loads, %0d samples) over %0d epsilon settings",
             words_in, param_words, sample_words, eps_settings);
    $display("checked %0d outputs, %0d clipped, %0d mismatches",
             results_seen, clipped_seen, mismatches);
    if (mismatches == 0 && expected_y_q.size() == 0) begin
      $display("batchnorm_inference_affine test passed");
    end else begin
      $display("batchnorm_inference_affine test failed");
    end
    $finish;
  end

endmodule
